// ----- sv/b64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet lookup for the Base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    // Position within the three-byte group
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // ASCII '=' used for padding
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Characters per byte, at most four (one byte plus flush and two pads)
    localparam int unsigned SLOTS = 4;

    // One classified byte: the characters it produces, in order
    typedef struct packed {
        logic [SLOTS-1:0][5:0] sextet;   // six-bit code per slot
        logic [SLOTS-1:0]      pad;      // slot is an '=' pad
        logic [1:0]            last_idx; // index of the final slot used
        logic                  fin;      // final byte of the message
    } job_t;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ----- sv/b64enc_if.sv -----
// ----------------------------------------------------------------------------
// b64enc_if
// Valid/ready channels: raw bytes in, encoded characters out.
// ----------------------------------------------------------------------------
interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- sv/b64enc_front.sv -----
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts bytes, tracks the group position and carry bits, and turns each
// byte into a job listing the characters it produces.
// ----------------------------------------------------------------------------
module b64enc_front (
    input  logic              clk,
    input  logic              rst_n,
    b64enc_byte_if.sink       byte_ch,
    input  logic              q_full,
    output logic              push,
    output b64enc_pkg::job_t  job
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] carry_reg;
    logic [3:0] carry_next;
    logic [7:0] b;
    logic       fin;

    assign byte_ch.ready = !q_full;
    assign push          = byte_ch.valid && !q_full;
    assign b             = byte_ch.data_byte;
    assign fin           = byte_ch.final_byte;

    // Classify the byte by group position
    always_comb
    begin
        job          = '0;
        job.fin      = fin;
        phase_next   = b64enc_pkg::PHASE_0;
        carry_next   = 4'd0;
        case (phase_reg)
            b64enc_pkg::PHASE_1:
            begin
                job.sextet[0] = {carry_reg[1:0], b[7:4]};
                if (fin)
                begin
                    job.sextet[1] = {b[3:0], 2'b00};
                    job.pad[2]    = 1'b1;
                    job.last_idx  = 2'd2;
                end
                else
                begin
                    job.last_idx = 2'd0;
                    phase_next   = b64enc_pkg::PHASE_2;
                    carry_next   = b[3:0];
                end
            end
            b64enc_pkg::PHASE_2:
            begin
                job.sextet[0] = {carry_reg, b[7:6]};
                job.sextet[1] = b[5:0];
                job.last_idx  = 2'd1;
            end
            default:
            begin
                // Group start; the unused fourth code behaves the same
                job.sextet[0] = b[7:2];
                if (fin)
                begin
                    job.sextet[1] = {b[1:0], 4'b0000};
                    job.pad[2]    = 1'b1;
                    job.pad[3]    = 1'b1;
                    job.last_idx  = 2'd3;
                end
                else
                begin
                    job.last_idx = 2'd0;
                    phase_next   = b64enc_pkg::PHASE_1;
                    carry_next   = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    // Group position and carry advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64enc_pkg::PHASE_0;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ----- sv/b64enc_queue.sv -----
// ----------------------------------------------------------------------------
// b64enc_queue
// Small FIFO of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module b64enc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64enc_pkg::job_t  push_job,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output b64enc_pkg::job_t  head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64enc_pkg::job_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/b64enc_back.sv -----
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the slots of the head job into the output register, one character
// per cycle while the queue holds a job and char_ch does not stall.
// ----------------------------------------------------------------------------
module b64enc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  b64enc_pkg::job_t  head_job,
    output logic              pop,
    b64enc_char_if.source     char_ch
);

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       last_char_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       slot_last;
    logic [7:0] char_next;

    assign load      = !q_empty && (!out_valid_reg || char_ch.ready);
    assign slot_last = (idx_reg == head_job.last_idx);
    assign pop       = load && slot_last;

    // Character for the current slot
    always_comb
    begin
        if (head_job.pad[idx_reg])
        begin
            char_next = b64enc_pkg::PAD_CHAR;
        end
        else
        begin
            char_next = b64enc_pkg::sextet_to_ascii(head_job.sextet[idx_reg]);
        end
    end

    // Slot index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= slot_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (char_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg  <= char_next;
            last_char_reg <= head_job.fin && slot_last;
        end
    end

    assign char_ch.valid     = out_valid_reg;
    assign char_ch.out_char  = out_char_reg;
    assign char_ch.last_char = last_char_reg;

endmodule

// ----- sv/base64_stream_encoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Base64 (standard alphabet, '=' padding) encoder for a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch carries one message byte per transaction; final_byte marks the
//   last byte of a message. char_ch carries one ASCII character per
//   transaction; last_char marks the last character of the encoded message.
//   Each byte gives one or two characters, and up to four on a final byte.
// Path: an accepted byte is written into the queue as a job; its characters
//   then pass one by one through the output register onto char_ch.
// Flow: the back end emits one character per cycle, while char_ch is ready
//   and the queue holds a job, from the head job of a QUEUE_DEPTH-entry queue;
//   a group of 3 bytes gives 4 characters, and a final byte gives up to 4.
//   byte_ch.ready drops only while the queue is full.
// Reset: clears the group position and carry, the queue and the output
//   valid flag; the next byte starts a new group.
// Stall: a stalled char_ch holds its character; jobs collect in the queue
//   and byte_ch.ready falls once it fills. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    b64enc_byte_if.sink    byte_ch,
    b64enc_char_if.source  char_ch
);

    b64enc_pkg::job_t push_job;
    b64enc_pkg::job_t head_job;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    b64enc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_full  (q_full),
        .push    (push),
        .job     (push_job)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_job (head_job)
    );

    b64enc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head_job (head_job),
        .pop      (pop),
        .char_ch  (char_ch)
    );

endmodule
